@@ hdl/iirdf_pkg.sv @@
// Shared constants, types and command codes for the direct-form IIR filter.
`default_nettype none
package iirdf_pkg;

  localparam int MAX_FF_TAPS    = 16;
  localparam int MAX_FB_TAPS    = 8;
  localparam int COEF_FRAC_BITS = 14;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + $clog2(MAX_FF_TAPS + MAX_FB_TAPS) + 1;
  localparam int Q_W      = ACC_W - COEF_FRAC_BITS;

  localparam int FF_IDX_W = (MAX_FF_TAPS > 1) ? $clog2(MAX_FF_TAPS) : 1;
  localparam int FB_IDX_W = (MAX_FB_TAPS > 1) ? $clog2(MAX_FB_TAPS) : 1;
  localparam int FF_CNT_W = $clog2(MAX_FF_TAPS + 1);
  localparam int FB_CNT_W = $clog2(MAX_FB_TAPS + 1);
  localparam int TAP_W    = (FF_IDX_W > FB_IDX_W) ? FF_IDX_W : FB_IDX_W;

  localparam int FF_TAPS_W = 5;
  localparam int FB_TAPS_W = 4;
  localparam int CFG_W     = 5;
  localparam int IDX_W     = 4;

  localparam int S_DATA_W = 40;
  localparam int M_DATA_W = 16;

  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_FF_COEF = 2'd1,
    CMD_FB_COEF = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic {
    REG_FF_TAPS = 1'b0,
    REG_FB_TAPS = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

endpackage : iirdf_pkg
`default_nettype wire

@@ hdl/iirdf_mac.sv @@
// Shared multiply-accumulate unit: registered product, then wide accumulate.
`default_nettype none
module iirdf_mac (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire iirdf_pkg::mac_ctrl_t                ctrl,
  input  wire logic signed [iirdf_pkg::SAMPLE_W-1:0] op_a,
  input  wire logic signed [iirdf_pkg::COEF_W-1:0]   op_b,
  output logic signed      [iirdf_pkg::ACC_W-1:0]    acc
);
  import iirdf_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic                     prod_vld;

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
    if (rst) begin
      prod_vld <= 1'b0;
      acc      <= '0;
    end else begin
      prod_vld <= ctrl.valid;
      if (ctrl.clear) begin
        acc <= '0;
      end else if (prod_vld) begin
        acc <= acc + ACC_W'(prod);
      end
    end
  end

endmodule : iirdf_mac
`default_nettype wire

@@ hdl/iir_filter_direct_form.sv @@
// Top level of the direct-form IIR filter: sequencer, histories, coefficients.
// Usage:
//   Input beats arrive on s_axis_*; each carries a command. A sample command
//   produces one output beat on m_axis_*; coefficient writes and the clear
//   command produce none, absorbed in the cycle they are accepted. The user
//   sets ff_taps and fb_taps via the cfg_* write port while idle; unenforced.
// Sequencing:
//   An accepted sample steps through ST_FF once per feedforward tap, ST_FB
//   once per feedback tap (nff, nfb = clamped tap counts), then ST_DRAIN and
//   ST_DONE, which loads the output register and returns to ST_IDLE.
//   One shared 16x16 multiplier plus accumulator handles one tap per cycle;
//   the tap loop sets the rate. s_axis_tready is high only while the
//   sequencer idles.
// Reset:
//   rst (synchronous) zeroes histories, coefficients and pointers and sets
//   both tap counts to 1. No output beat is pending afterwards.
// Stall:
//   A finished result waits in the output register; the next input beat is
//   still taken. A following sample holds in its last step until the output
//   register is free.
`default_nettype none
module iir_filter_direct_form (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // tdata: command[1:0], sample_in[17:2], coef_index[21:18], coef_value[37:22]
  input  wire logic [iirdf_pkg::S_DATA_W-1:0]    s_axis_tdata,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // tdata: sample_out[15:0]
  output logic [iirdf_pkg::M_DATA_W-1:0]         m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              cfg_wr_en,
  input  wire logic                              cfg_index,
  input  wire logic [iirdf_pkg::CFG_W-1:0]       cfg_data
);
  import iirdf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FF,
    ST_FB,
    ST_DRAIN,
    ST_DONE
  } state_t;

  state_t state;

  logic signed [SAMPLE_W-1:0] input_history  [MAX_FF_TAPS];
  logic signed [SAMPLE_W-1:0] output_history [MAX_FB_TAPS];
  logic signed [COEF_W-1:0]   ff_coefs       [MAX_FF_TAPS];
  logic signed [COEF_W-1:0]   fb_coefs       [MAX_FB_TAPS];
  logic [FF_IDX_W-1:0]        input_ptr;
  logic [FB_IDX_W-1:0]        output_ptr;
  logic [FF_TAPS_W-1:0]       ff_taps;
  logic [FB_TAPS_W-1:0]       fb_taps;
  logic [TAP_W-1:0]           tap;

  cmd_t                       in_cmd;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic [IDX_W-1:0]           in_cidx;
  logic signed [COEF_W-1:0]   in_cval;
  logic                       in_fire;

  logic [FF_CNT_W-1:0]        nff;
  logic [FB_CNT_W-1:0]        nfb;
  logic                       ff_last;
  logic                       fb_last;
  logic [FF_IDX_W:0]          ff_sub;
  logic [FF_IDX_W-1:0]        in_idx;
  logic [FB_IDX_W:0]          fb_off;
  logic [FB_IDX_W-1:0]        out_idx;

  mac_ctrl_t                  mac_ctrl;
  logic signed [SAMPLE_W-1:0] op_a;
  logic signed [COEF_W-1:0]   op_b;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    acc_biased;
  logic signed [Q_W-1:0]      quot;
  logic signed [SAMPLE_W-1:0] sat;
  logic                       out_free;

  assign in_cmd    = cmd_t'(s_axis_tdata[1:0]);
  assign in_sample = s_axis_tdata[17:2];
  assign in_cidx   = s_axis_tdata[21:18];
  assign in_cval   = s_axis_tdata[37:22];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    if (ff_taps == '0) begin
      nff = FF_CNT_W'(1);
    end else if (int'(ff_taps) > MAX_FF_TAPS) begin
      nff = FF_CNT_W'(MAX_FF_TAPS);
    end else begin
      nff = FF_CNT_W'(ff_taps);
    end
    if (fb_taps == '0) begin
      nfb = FB_CNT_W'(1);
    end else if (int'(fb_taps) > MAX_FB_TAPS) begin
      nfb = FB_CNT_W'(MAX_FB_TAPS);
    end else begin
      nfb = FB_CNT_W'(fb_taps);
    end
  end

  assign ff_last = (FF_CNT_W'(tap) + FF_CNT_W'(1)) == nff;
  assign fb_last = (FB_CNT_W'(tap) + FB_CNT_W'(1)) == nfb;

  // newest input at input_ptr; feedback tap k reads output_ptr - 1 - k
  always_comb begin
    ff_sub = (FF_IDX_W + 1)'(tap);
    if ({1'b0, input_ptr} >= ff_sub) begin
      in_idx = FF_IDX_W'({1'b0, input_ptr} - ff_sub);
    end else begin
      in_idx = FF_IDX_W'({1'b0, input_ptr} + (FF_IDX_W + 1)'(MAX_FF_TAPS) - ff_sub);
    end
    fb_off = (FB_IDX_W + 1)'(tap) + (FB_IDX_W + 1)'(1);
    if ({1'b0, output_ptr} >= fb_off) begin
      out_idx = FB_IDX_W'({1'b0, output_ptr} - fb_off);
    end else begin
      out_idx = FB_IDX_W'({1'b0, output_ptr} + (FB_IDX_W + 1)'(MAX_FB_TAPS) - fb_off);
    end
  end

  always_comb begin
    mac_ctrl.clear = in_fire;
    mac_ctrl.valid = (state == ST_FF) || (state == ST_FB);
    if (state == ST_FB) begin
      op_a = output_history[out_idx];
      op_b = fb_coefs[tap[FB_IDX_W-1:0]];
    end else begin
      op_a = input_history[in_idx];
      op_b = ff_coefs[tap[FF_IDX_W-1:0]];
    end
  end

  iirdf_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mac_ctrl),
    .op_a (op_a),
    .op_b (op_b),
    .acc  (acc)
  );

  // divide by 2^COEF_FRAC_BITS toward zero, then saturate
  always_comb begin
    acc_biased = acc[ACC_W-1] ? acc + ACC_W'((1 << COEF_FRAC_BITS) - 1) : acc;
    quot       = Q_W'(acc_biased >>> COEF_FRAC_BITS);
    if (quot > Q_W'(32767)) begin
      sat = 16'sh7fff;
    end else if (quot < -Q_W'(32768)) begin
      sat = 16'sh8000;
    end else begin
      sat = SAMPLE_W'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      tap           <= '0;
      input_ptr     <= '0;
      output_ptr    <= '0;
      ff_taps       <= FF_TAPS_W'(1);
      fb_taps       <= FB_TAPS_W'(1);
      m_axis_tvalid <= 1'b0;
      m_axis_tdata  <= '0;
      for (int i = 0; i < MAX_FF_TAPS; i++) begin
        input_history[i] <= '0;
        ff_coefs[i]      <= '0;
      end
      for (int i = 0; i < MAX_FB_TAPS; i++) begin
        output_history[i] <= '0;
        fb_coefs[i]       <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        unique case (reg_idx_t'(cfg_index))
          REG_FF_TAPS: ff_taps <= cfg_data[FF_TAPS_W-1:0];
          REG_FB_TAPS: fb_taps <= cfg_data[FB_TAPS_W-1:0];
          default: ;
        endcase
      end

      // ST_DONE reloads the output register itself
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            unique case (in_cmd)
              CMD_SAMPLE: begin
                input_history[input_ptr] <= in_sample;
                tap   <= '0;
                state <= ST_FF;
              end
              CMD_FF_COEF: begin
                if (int'(in_cidx) < MAX_FF_TAPS) begin
                  ff_coefs[in_cidx[FF_IDX_W-1:0]] <= in_cval;
                end
              end
              CMD_FB_COEF: begin
                if (int'(in_cidx) < MAX_FB_TAPS) begin
                  fb_coefs[in_cidx[FB_IDX_W-1:0]] <= in_cval;
                end
              end
              CMD_CLEAR: begin
                for (int i = 0; i < MAX_FF_TAPS; i++) begin
                  input_history[i] <= '0;
                end
                for (int i = 0; i < MAX_FB_TAPS; i++) begin
                  output_history[i] <= '0;
                end
                input_ptr  <= '0;
                output_ptr <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_FF: begin
          if (ff_last) begin
            tap   <= '0;
            state <= ST_FB;
          end else begin
            tap <= tap + TAP_W'(1);
          end
        end
        ST_FB: begin
          if (fb_last) begin
            state <= ST_DRAIN;
          end else begin
            tap <= tap + TAP_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            m_axis_tdata               <= sat;
            m_axis_tvalid              <= 1'b1;
            output_history[output_ptr] <= sat;
            input_ptr  <= (int'(input_ptr) == MAX_FF_TAPS - 1) ? '0
                        : input_ptr + FF_IDX_W'(1);
            output_ptr <= (int'(output_ptr) == MAX_FB_TAPS - 1) ? '0
                        : output_ptr + FB_IDX_W'(1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule : iir_filter_direct_form
`default_nettype wire

@@ tb/iir_filter_direct_form_tb.sv @@
// Self-checking testbench for iir_filter_direct_form: directed table, then random phases.
`timescale 1ns / 1ps
module iir_filter_direct_form_tb;
  import iirdf_pkg::*;

  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 40;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 188;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic                cfg_index = REG_FF_TAPS;
  logic [CFG_W-1:0]    cfg_data = '0;

  iir_filter_direct_form DUT (
    .clk(clk),
    .rst(rst),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // filter predictor state
  logic signed [15:0] x_hist [MAX_FF_TAPS];
  logic signed [15:0] y_hist [MAX_FB_TAPS];
  logic signed [15:0] ff_coef [MAX_FF_TAPS];
  logic signed [15:0] fb_coef [MAX_FB_TAPS];
  logic [3:0]         x_ptr;
  logic [2:0]         y_ptr;
  logic [4:0]         ff_cfg;
  logic [3:0]         fb_cfg;

  logic signed [15:0] expected_out_q [$];
  int                 errors = 0;
  int                 idle_cycles = 0;
  bit                 steady = 1'b0;
  int                 out_stall = 0;

  typedef struct {
    cmd_t               cmd;
    logic signed [15:0] smp;
    logic [3:0]         idx;
    logic signed [15:0] val;
    bit                 chk;
    logic signed [15:0] want;
  } row_t;

  row_t directed_rows [$];

  function automatic void clear_history();
    foreach (x_hist[i]) x_hist[i] = '0;
    foreach (y_hist[i]) y_hist[i] = '0;
    x_ptr = '0;
    y_ptr = '0;
  endfunction

  // Returns 1 when the beat yields an output sample, placed in y.
  function automatic bit filter_beat(input cmd_t cmd, input logic signed [15:0] smp,
                                     input logic [3:0] idx, input logic signed [15:0] val,
                                     output logic signed [15:0] y);
    int     nff;
    int     nfb;
    longint acc;
    longint q;
    logic [3:0] xi;
    logic [2:0] yi;
    y = '0;
    if (cmd == CMD_FF_COEF) begin
      ff_coef[idx] = val;
      return 1'b0;
    end
    if (cmd == CMD_FB_COEF) begin
      if (idx < MAX_FB_TAPS) fb_coef[idx[2:0]] = val;
      return 1'b0;
    end
    if (cmd == CMD_CLEAR) begin
      clear_history();
      return 1'b0;
    end
    nff = (ff_cfg == 0) ? 1 : (ff_cfg > MAX_FF_TAPS) ? MAX_FF_TAPS : int'(ff_cfg);
    nfb = (fb_cfg == 0) ? 1 : (fb_cfg > MAX_FB_TAPS) ? MAX_FB_TAPS : int'(fb_cfg);
    x_hist[x_ptr] = smp;
    acc = 0;
    for (int k = 0; k < nff; k++) begin
      xi = x_ptr - 4'(k);
      acc += longint'(x_hist[xi]) * longint'(ff_coef[k]);
    end
    for (int k = 0; k < nfb; k++) begin
      yi = y_ptr - 3'(k + 1);
      acc += longint'(y_hist[yi]) * longint'(fb_coef[k]);
    end
    q = acc / (longint'(1) << COEF_FRAC_BITS);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    y = 16'(q);
    y_hist[y_ptr] = y;
    x_ptr = x_ptr + 4'd1;
    y_ptr = y_ptr + 3'd1;
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic put_beat(input cmd_t cmd, input logic signed [15:0] smp,
                          input logic [3:0] idx, input logic signed [15:0] val,
                          input bit chk, input logic signed [15:0] want);
    int gap;
    logic signed [15:0] y;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= {2'b00, val, idx, smp, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (filter_beat(cmd, smp, idx, val, y)) expected_out_q.push_back(chk ? want : y);
  endtask

  task automatic set_taps(input logic [CFG_W-1:0] ff, input logic [CFG_W-1:0] fb);
    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_FF_TAPS;
    cfg_data  <= ff;
    @(posedge clk);
    cfg_index <= REG_FB_TAPS;
    cfg_data  <= fb;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    ff_cfg = ff;
    fb_cfg = fb[3:0];
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3: return 16'($urandom_range(0, 2000)) - 16'sd1000;
      default: return 16'($urandom);
    endcase
  endfunction

  // output side: random stalls and checking
  always @(posedge clk) begin
    if (out_stall > 0) begin
      out_stall = out_stall - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady && $urandom_range(9) == 0) out_stall = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_out_q.size() == 0) begin
        $display("%0t: unexpected output beat, expected none, got %0d",
                 $time, $signed(m_axis_tdata));
        errors++;
      end else begin
        if ($signed(m_axis_tdata) !== expected_out_q[0]) begin
          $display("%0t: sample_out mismatch, expected %0d, got %0d",
                   $time, expected_out_q[0], $signed(m_axis_tdata));
          errors++;
        end
        void'(expected_out_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d output beats still expected", $time,
               expected_out_q.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t r;
    cmd_t cmd;
    logic [CFG_W-1:0] ff_set;
    logic [CFG_W-1:0] fb_set;
    int   pick;
    int   done;

    clear_history();
    foreach (ff_coef[i]) ff_coef[i] = '0;
    foreach (fb_coef[i]) fb_coef[i] = '0;
    ff_cfg = 5'd1;
    fb_cfg = 4'd1;

    //                     cmd          sample      idx    coef       chk   want
    directed_rows.push_back('{CMD_SAMPLE,  16'sh7fff, 4'd0,  16'sd0,    1'b1, 16'sd0});
    directed_rows.push_back('{CMD_SAMPLE,  16'sh8000, 4'd0,  16'sd0,    1'b1, 16'sd0});
    directed_rows.push_back('{CMD_FF_COEF, 16'sd0,    4'd0,  16'sd16384, 1'b0, 16'sd0});
    directed_rows.push_back('{CMD_SAMPLE,  16'sh8000, 4'd0,  16'sd0,    1'b1, 16'sh8000});
    directed_rows.push_back('{CMD_SAMPLE,  16'sh7fff, 4'd0,  16'sd0,    1'b1, 16'sh7fff});
    directed_rows.push_back('{CMD_FF_COEF, 16'sd0,    4'd0,  16'sh8000, 1'b0, 16'sd0});
    directed_rows.push_back('{CMD_SAMPLE,  16'sh8000, 4'd0,  16'sd0,    1'b1, 16'sh7fff});
    directed_rows.push_back('{CMD_SAMPLE,  16'sh7fff, 4'd0,  16'sd0,    1'b1, 16'sh8000});
    directed_rows.push_back('{CMD_SAMPLE,  16'sd1,    4'd0,  16'sd0,    1'b1, -16'sd2});
    directed_rows.push_back('{CMD_FF_COEF, 16'sd0,    4'd0,  16'sd1,    1'b0, 16'sd0});
    // truncation toward zero, not down
    directed_rows.push_back('{CMD_SAMPLE,  -16'sd1,   4'd0,  16'sd0,    1'b1, 16'sd0});
    directed_rows.push_back('{CMD_FF_COEF, 16'sd0,    4'd15, 16'sh7fff, 1'b0, 16'sd0});
    directed_rows.push_back('{CMD_FB_COEF, 16'sd0,    4'd0,  16'sd8192, 1'b0, 16'sd0});
    directed_rows.push_back('{CMD_FB_COEF, 16'sd0,    4'd7,  16'sh8000, 1'b0, 16'sd0});
    // feedback index past the store: dropped
    directed_rows.push_back('{CMD_FB_COEF, 16'sd0,    4'd8,  16'sd12345, 1'b0, 16'sd0});
    directed_rows.push_back('{CMD_FB_COEF, 16'sd0,    4'd15, -16'sd1,   1'b0, 16'sd0});
    directed_rows.push_back('{CMD_FF_COEF, 16'sd0,    4'd0,  16'sd20000, 1'b0, 16'sd0});
    directed_rows.push_back('{CMD_SAMPLE,  16'sd16384, 4'd0, 16'sd0,    1'b0, 16'sd0});
    directed_rows.push_back('{CMD_SAMPLE,  -16'sd20000, 4'd0, 16'sd0,   1'b0, 16'sd0});
    directed_rows.push_back('{CMD_SAMPLE,  16'sd3,    4'd0,  16'sd0,    1'b0, 16'sd0});
    directed_rows.push_back('{CMD_CLEAR,   16'sd0,    4'd0,  16'sd0,    1'b0, 16'sd0});
    directed_rows.push_back('{CMD_FF_COEF, 16'sd0,    4'd0,  16'sd1,    1'b0, 16'sd0});
    // history cleared, tiny gain
    directed_rows.push_back('{CMD_SAMPLE,  16'sd100,  4'd0,  16'sd0,    1'b1, 16'sd0});
    directed_rows.push_back('{CMD_SAMPLE,  16'sd0,    4'd0,  16'sd0,    1'b1, 16'sd0});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      put_beat(r.cmd, r.smp, r.idx, r.val, r.chk, r.want);
    end
    s_axis_tvalid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ff_set = 5'd16; fb_set = 5'd8;  end
        1: begin ff_set = 5'd0;  fb_set = 5'd16; end
        2: begin ff_set = 5'd31; fb_set = 5'd31; end
        3: begin ff_set = 5'd17; fb_set = 5'd9;  end
        4: begin ff_set = 5'd5;  fb_set = 5'd3;  end
        5: begin ff_set = 5'd1;  fb_set = 5'd1;  end
        default: begin
          ff_set = 5'($urandom_range(0, 31));
          fb_set = 5'($urandom_range(0, 31));
        end
      endcase
      set_taps(ff_set, fb_set);
      steady = (p % 3 == 2);
      done = 0;
      while (done < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        cmd = (pick < 70) ? CMD_SAMPLE : (pick < 82) ? CMD_FF_COEF :
              (pick < 94) ? CMD_FB_COEF : CMD_CLEAR;
        r.cmd = cmd;
        r.smp = rand_sample();
        r.idx = 4'($urandom);
        r.val = 16'($urandom);
        if (cmd == CMD_FB_COEF) begin
          if ($urandom_range(9) != 0) r.idx = 4'($urandom_range(0, 7));
          if ($urandom_range(3) != 0) r.val = 16'($urandom_range(0, 8000)) - 16'sd4000;
        end else if (cmd == CMD_FF_COEF && $urandom_range(1) == 0) begin
          r.val = 16'($urandom_range(0, 12000)) - 16'sd6000;
        end
        put_beat(r.cmd, r.smp, r.idx, r.val, 1'b0, 16'sd0);
        if (!(cmd == CMD_FB_COEF && r.idx >= MAX_FB_TAPS)) done++;
      end
      s_axis_tvalid <= 1'b0;
    end

    while (expected_out_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
